@@ rtl/kgl_pkg.sv @@
// Package for the key-click gain limiter: payload structs, register indexes,
// fixed-point constants. No dependencies.
package kgl_pkg;

   localparam int FrameSize = 480;
   localparam int PosWidth = $clog2(FrameSize);

   localparam logic [15:0] KEY_MARKER = 16'hACDC;
   localparam logic [5:0] KEY_NONE_ID = 6'd48;
   localparam logic [5:0] KEY_DEFAULT_ID = 6'd49;
   localparam logic [16:0] GAIN_ONE = 17'h10000;
   localparam logic [23:0] ENV_RESET = 24'd83886;

   typedef enum logic [2:0] {
      CSR_ENABLE = 3'd0,
      CSR_FRAMES_TO_HOLD = 3'd1,
      CSR_GAIN_RISE = 3'd2,
      CSR_GAIN_FALL = 3'd3,
      CSR_ENV_COEFF = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic kind;
      logic signed [15:0] sample_in;
      logic [31:0] word_now;
      logic [31:0] word_next;
      logic next_present;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [5:0] key_id;
      logic key_down;
      logic removal_active;
      logic frame_end;
   } rsp_type;

   // Classified request handed from front to back.
   typedef struct packed {
      logic is_sample;
      logic is_event;      // valid marked control word with enable set
      logic [5:0] key;
      logic neg;
      logic [15:0] mag;
   } cmd_type;

   // 48-bit key vector decode: first set index, none, or default.
   function automatic logic [5:0] decode_key(input logic [31:0] now,
                                             input logic [31:0] nxt,
                                             input logic present);
      logic [47:0] bits;
      logic [5:0] id;
      logic [5:0] cnt;
      bits = '0;
      id = KEY_NONE_ID;
      cnt = '0;
      for (int i = 0; i < 16; i++) bits[i] = now[15 - i];
      for (int i = 16; i < 48; i++) bits[i] = nxt[47 - i];
      for (int i = 47; i >= 0; i--) begin
         if (bits[i]) id = 6'(i);
         cnt = cnt + 6'(bits[i]);
      end
      if (!present || cnt > 6'd1) id = KEY_DEFAULT_ID;
      return id;
   endfunction

endpackage

@@ rtl/kgl_front.sv @@
// Front end: accepts requests, decodes key words and sample magnitudes.
// Depends on kgl_pkg.
module kgl_front import kgl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   input  logic    enable,
   output cmd_type cmd
);
   logic [15:0] raw;
   assign raw = in_req.sample_in;

   // Classify request
   always_comb begin
      cmd.is_sample = !in_req.kind;
      cmd.is_event  = in_req.kind && enable && (in_req.word_now[31:16] == KEY_MARKER);
      cmd.key       = decode_key(in_req.word_now, in_req.word_next, in_req.next_present);
      cmd.neg       = raw[15];
      cmd.mag       = raw[15] ? (16'h0 - raw) : raw;
   end

   assert property (@(posedge clock) disable iff (reset)
      in_valid && cmd.is_event |-> !cmd.is_sample)
      else $error("event classified as sample");
   assert property (@(posedge clock) disable iff (reset)
      in_valid && cmd.is_sample && !cmd.neg |-> cmd.mag[15] == 1'b0)
      else $error("positive magnitude overflow");
endmodule

@@ rtl/kgl_queue.sv @@
// Two-entry queue between front and back.
// Depends on kgl_pkg.
module kgl_queue import kgl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    nonempty,
   output cmd_type rd_data
);
   cmd_type mem_ff [2];
   logic wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign nonempty = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rptr_ff];

   // Pointer and count update
   always_comb begin
      wptr_in = wptr_ff ^ wr_en;
      rptr_in = rptr_ff ^ rd_en;
      cnt_in = cnt_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wptr_ff] <= wr_data;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en) else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      !nonempty |-> !rd_en) else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
endmodule

@@ rtl/kgl_back.sv @@
// Back end: gain/envelope datapath and key/frame state machine, with an
// output register. Depends on kgl_pkg.
module kgl_back import kgl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   input  logic        enable,
   input  logic [7:0]  frames_to_hold,
   input  logic [15:0] gain_rise,
   input  logic [15:0] gain_fall,
   input  logic [15:0] env_coeff,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        rsp_take
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_ENV, ST_GAIN, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [16:0] gain_ff, gain_in;
   logic [23:0] env_ff, env_in;
   logic key_down_ff, key_down_in;
   logic removal_ff, removal_in;
   logic mode_ff, mode_in;
   logic [7:0] fcnt_ff, fcnt_in;
   logic [5:0] key_ff, key_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   cmd_type cur_ff, cur_in;
   logic [15:0] omag_ff, omag_in;
   logic [39:0] acc_ff, acc_in;
   logic fend_ff, fend_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [32:0] prod_mag;
   logic [23:0] mag23;
   logic [15:0] factor;
   logic [32:0] gprod;
   logic [18:0] gshift;
   logic [39:0] env_a, env_b;
   logic [16:0] cw;
   logic [7:0] fcnt_inc;

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   // Datapath: magnitude, gain and envelope products
   always_comb begin
      prod_mag = {16'h0, cur_ff.mag} * gain_ff;
      mag23 = {omag_ff, 8'h0};
      factor = (mode_ff && (mag23 > env_ff)) ? gain_fall : gain_rise;
      gprod = gain_ff * {1'b0, factor};
      gshift = gprod[32:14];
      cw = 17'h10000 - {1'b0, env_coeff};
      env_a = env_ff * env_coeff;
      env_b = mag23 * cw;
      fcnt_inc = fcnt_ff + 8'd1;
   end

   // Sequencer and state update
   always_comb begin
      state_in = state_ff;
      gain_in = gain_ff;
      env_in = env_ff;
      key_down_in = key_down_ff;
      removal_in = removal_ff;
      mode_in = mode_ff;
      fcnt_in = fcnt_ff;
      key_in = key_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      omag_in = omag_ff;
      acc_in = acc_ff;
      fend_in = fend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd;
               fend_in = 1'b0;
               if (cmd.is_sample) begin
                  if (pos_ff == '0) mode_in = removal_ff && enable;
                  state_in = ST_MUL;
               end else begin
                  if (cmd.is_event) begin
                     key_in = cmd.key;
                     if (cmd.key != KEY_NONE_ID) begin
                        key_down_in = 1'b1;
                        removal_in = 1'b1;
                     end else if (key_down_ff) begin
                        key_down_in = 1'b0;
                        removal_in = 1'b1;
                     end
                     fcnt_in = '0;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            omag_in = prod_mag[31:16];
            state_in = ST_ENV;
         end
         ST_ENV: begin
            acc_in = env_a;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in = (gshift > 19'(GAIN_ONE)) ? GAIN_ONE : gshift[16:0];
            if (!mode_ff) env_in = 24'((acc_ff + env_b) >> 16);
            if (32'(pos_ff) + 32'd1 >= 32'(FrameSize)) begin
               fend_in = 1'b1;
               pos_in = '0;
               if (mode_ff) begin
                  fcnt_in = fcnt_inc;
                  if (fcnt_inc >= frames_to_hold) begin
                     removal_in = 1'b0;
                     key_in = KEY_NONE_ID;
                     fcnt_in = '0;
                  end
               end
            end else begin
               pos_in = pos_ff + PosWidth'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_in.sample_out = cur_ff.is_sample
                  ? (cur_ff.neg ? (16'h0 - omag_ff) : omag_ff) : 16'h0;
               rsp_in.key_id = key_ff;
               rsp_in.key_down = key_down_ff;
               rsp_in.removal_active = removal_ff;
               rsp_in.frame_end = cur_ff.is_sample && fend_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      omag_ff <= omag_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff <= GAIN_ONE;
         env_ff <= ENV_RESET;
         key_down_ff <= 1'b0;
         removal_ff <= 1'b0;
         mode_ff <= 1'b0;
         fcnt_ff <= '0;
         key_ff <= KEY_NONE_ID;
         pos_ff <= '0;
         fend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gain_ff <= gain_in;
         env_ff <= env_in;
         key_down_ff <= key_down_in;
         removal_ff <= removal_in;
         mode_ff <= mode_in;
         fcnt_ff <= fcnt_in;
         key_ff <= key_in;
         pos_ff <= pos_in;
         fend_ff <= fend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE) else $error("gain above unity");
   assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < 32'(FrameSize)) else $error("sample position out of frame");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_take |=> $stable(rsp_ff))
      else $error("held result changed");
endmodule

@@ rtl/keyclick_gain_limiter_core.sv @@
// Key-click gain limiter, top level: CSR bank, front, queue, back.
// Depends on kgl_pkg, kgl_front, kgl_queue, kgl_back.
//
// Usage:
//  Requests enter as a queue: req_push while req_full is low. Each request
//  (sample or key control word) gives exactly one result, read as a queue:
//  the oldest result stands on rsp_data while rsp_empty is low and leaves
//  on rsp_pop.
//  The front decodes a request in the cycle it is accepted and stores it in
//  a two-entry queue. The back runs one request at a time: a sample passes
//  through start, magnitude multiply, envelope multiply, gain multiply and
//  result, a control word through start and result; the result step
//  waits while the held result is not popped.
//  CSR writes (csr_valid/csr_ready, always ready) must go in only while the
//  block is idle; the user must keep to this, the block does not enforce it.
//  Reset (synchronous) restores the default registers, unity gain and the
//  initial envelope. When the receiver does not pop, the result stays
//  registered, the back stalls, then the queue fills and req_full rises.
module keyclick_gain_limiter_core import kgl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic enable_ff;
   logic [7:0] fth_ff;
   logic [15:0] rise_ff, fall_ff, coeff_ff;
   cmd_type cmd_f, cmd_q;
   logic q_nonempty, q_take, rsp_valid, push_ok;

   assign csr_ready = 1'b1;
   assign push_ok = req_push && !req_full;
   assign rsp_empty = !rsp_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         fth_ff <= 8'd5;
         rise_ff <= 16'd17203;
         fall_ff <= 16'd15565;
         coeff_ff <= 16'd65503;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_FRAMES_TO_HOLD: fth_ff <= csr_wdata[7:0];
            CSR_GAIN_RISE: rise_ff <= csr_wdata;
            CSR_GAIN_FALL: fall_ff <= csr_wdata;
            CSR_ENV_COEFF: coeff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   kgl_front u_front (
      .clock(clock), .reset(reset), .in_valid(push_ok), .in_req(req_data),
      .enable(enable_ff), .cmd(cmd_f)
   );

   kgl_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(push_ok), .wr_data(cmd_f),
      .full(req_full), .rd_en(q_take), .nonempty(q_nonempty), .rd_data(cmd_q)
   );

   kgl_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_nonempty), .cmd(cmd_q),
      .cmd_take(q_take), .enable(enable_ff), .frames_to_hold(fth_ff),
      .gain_rise(rise_ff), .gain_fall(fall_ff), .env_coeff(coeff_ff),
      .rsp_valid(rsp_valid), .rsp(rsp_data), .rsp_take(rsp_pop)
   );
endmodule
